// ===== design/abps_pkg.sv =====
// ----------------------------------------------------------------------------
// Active Brownian particle step unit package
// Shared widths, register indexes, operation codes, pipeline types and
// memory sizing helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package abps_pkg;

   localparam int PARTICLE_W = 10;
   localparam int POS_W      = 32;
   localparam int HEADING_W  = 16;
   localparam int NOISE_W    = 16;
   localparam int HGAIN_W    = 16;
   localparam int STEP_W     = 24;
   localparam int TRIG_W     = 16;
   localparam int HPROD_W    = HGAIN_W + 1 + NOISE_W;
   localparam int NPROD_W    = STEP_W + 1 + NOISE_W;

   localparam int NUM_PARTICLES_DEFAULT = 1024;
   localparam int SINE_LATENCY          = 6;

   localparam logic [HEADING_W-1:0] QUARTER_TURN = HEADING_W'(1 << (HEADING_W - 2));

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADING_GAIN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_STEP    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSITION_GAIN = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef struct packed {
      logic                  valid;
      logic                  live;
      logic                  op;
      logic [PARTICLE_W-1:0] particle;
   } tag_type;

   function automatic int mem_depth(int num);
      return (num < (1 << PARTICLE_W)) ? num : (1 << PARTICLE_W);
   endfunction

   function automatic int addr_width(int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

// ===== design/active_brownian_particle_step_unit.sv =====
// ----------------------------------------------------------------------------
// Active Brownian particle step unit
// One Euler-Maruyama step of an active Brownian particle per request, with
// per-particle position and heading held in on-chip memories.
//
// A request is taken at a rising edge with start high and busy low. A load
// request writes the particle's position and clears its heading; a step
// request adds scaled angle noise to the heading, then moves x and y by the
// step length times cos and sin of the heading plus scaled positional noise,
// saturating each coordinate. Requests to particles at or above
// NUM_PARTICLES change nothing and return zeros.
// Every request gives one result, marked by rsp_valid for one cycle. A new
// request can be taken every cycle while busy is low; requests to the same
// particle in consecutive cycles are forwarded inside the heading and
// position read-modify-write loops. The receiver cannot stall. After reset,
// busy stays high while all min(NUM_PARTICLES, 1024) heading memory entries
// are cleared; configuration writes are taken at any time and csr_ready is
// always high. The user must write registers only while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module active_brownian_particle_step_unit #(
   parameter int NUM_PARTICLES = abps_pkg::NUM_PARTICLES_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_op,
   input  wire logic [abps_pkg::PARTICLE_W-1:0]       req_particle,
   input  wire logic signed [abps_pkg::POS_W-1:0]     req_load_x,
   input  wire logic signed [abps_pkg::POS_W-1:0]     req_load_y,
   input  wire logic signed [abps_pkg::NOISE_W-1:0]   req_angle_noise,
   input  wire logic signed [abps_pkg::NOISE_W-1:0]   req_x_noise,
   input  wire logic signed [abps_pkg::NOISE_W-1:0]   req_y_noise,
   output logic                                       rsp_valid,
   output logic [abps_pkg::PARTICLE_W-1:0]            rsp_out_particle,
   output logic signed [abps_pkg::POS_W-1:0]          rsp_new_x,
   output logic signed [abps_pkg::POS_W-1:0]          rsp_new_y,
   output logic [abps_pkg::HEADING_W-1:0]             rsp_new_heading,
   output logic                                       rsp_saturated,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [abps_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [abps_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int LAST = abps_pkg::SINE_LATENCY + 2;

   typedef struct packed {
      abps_pkg::tag_type                       tag;
      logic signed [abps_pkg::POS_W-1:0]       load_x;
      logic signed [abps_pkg::POS_W-1:0]       load_y;
      logic signed [abps_pkg::NPROD_W-1:0]     x_nprod;
      logic signed [abps_pkg::NPROD_W-1:0]     y_nprod;
   } pipe_type;

   logic [abps_pkg::HGAIN_W-1:0]  heading_gain_ff;
   logic [abps_pkg::STEP_W-1:0]   speed_step_ff;
   logic [abps_pkg::STEP_W-1:0]   position_gain_ff;

   logic                          accept;
   logic                          clearing;
   pipe_type                      pipe_in;
   pipe_type                      pipe_ff [1:LAST];
   logic signed [abps_pkg::HPROD_W-1:0] hprod_ff;
   logic [abps_pkg::HEADING_W-1:0] heading_s2;
   logic [abps_pkg::HEADING_W-1:0] heading_dly_ff [abps_pkg::SINE_LATENCY];
   logic signed [abps_pkg::TRIG_W-1:0] cos_trig, sin_trig;

   assign accept    = start && !clearing;
   assign busy      = clearing;
   assign csr_ready = 1'b1;

   always_comb begin
      pipe_in.tag.valid    = accept;
      pipe_in.tag.live     = 32'(req_particle) < NUM_PARTICLES;
      pipe_in.tag.op       = req_op;
      pipe_in.tag.particle = req_particle;
      pipe_in.load_x       = req_load_x;
      pipe_in.load_y       = req_load_y;
      pipe_in.x_nprod      = $signed({1'b0, position_gain_ff}) * req_x_noise;
      pipe_in.y_nprod      = $signed({1'b0, position_gain_ff}) * req_y_noise;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_gain_ff  <= '0;
         speed_step_ff    <= '0;
         position_gain_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            abps_pkg::CSR_HEADING_GAIN: begin
               heading_gain_ff <= csr_wdata[abps_pkg::HGAIN_W-1:0];
            end
            abps_pkg::CSR_SPEED_STEP: begin
               speed_step_ff <= csr_wdata[abps_pkg::STEP_W-1:0];
            end
            abps_pkg::CSR_POSITION_GAIN: begin
               position_gain_ff <= csr_wdata[abps_pkg::STEP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LAST; k++) begin
            pipe_ff[k].tag.valid <= 1'b0;
         end
      end else begin
         pipe_ff[1] <= pipe_in;
         for (int k = 2; k <= LAST; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
      end
      hprod_ff          <= $signed({1'b0, heading_gain_ff}) * req_angle_noise;
      heading_dly_ff[0] <= heading_s2;
      for (int k = 1; k < abps_pkg::SINE_LATENCY; k++) begin
         heading_dly_ff[k] <= heading_dly_ff[k-1];
      end
   end

   abps_heading #(
      .NUM_PARTICLES (NUM_PARTICLES)
   ) u_heading (
      .clock       (clock),
      .reset       (reset),
      .rd_particle (req_particle),
      .s1_tag      (pipe_ff[1].tag),
      .s1_hprod    (hprod_ff),
      .heading_out (heading_s2),
      .busy        (clearing)
   );

   abps_sine u_cos (
      .clock (clock),
      .phase (heading_s2 + abps_pkg::QUARTER_TURN),
      .trig  (cos_trig)
   );

   abps_sine u_sin (
      .clock (clock),
      .phase (heading_s2),
      .trig  (sin_trig)
   );

   abps_position #(
      .NUM_PARTICLES (NUM_PARTICLES)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .in_tag       (pipe_ff[LAST].tag),
      .in_heading   (heading_dly_ff[abps_pkg::SINE_LATENCY-1]),
      .cos_trig     (cos_trig),
      .sin_trig     (sin_trig),
      .load_x       (pipe_ff[LAST].load_x),
      .load_y       (pipe_ff[LAST].load_y),
      .x_nprod      (pipe_ff[LAST].x_nprod),
      .y_nprod      (pipe_ff[LAST].y_nprod),
      .speed_step   (speed_step_ff),
      .out_valid    (rsp_valid),
      .out_particle (rsp_out_particle),
      .new_x        (rsp_new_x),
      .new_y        (rsp_new_y),
      .new_heading  (rsp_new_heading),
      .saturated    (rsp_saturated)
   );

endmodule

`default_nettype wire

// ===== design/abps_heading.sv =====
// ----------------------------------------------------------------------------
// Heading update stage
// Heading memory with a clearing pass after reset, read-modify-write of the
// wrapping heading with forwarding from the previous request.
// ----------------------------------------------------------------------------
`default_nettype none

module abps_heading #(
   parameter int NUM_PARTICLES = abps_pkg::NUM_PARTICLES_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [abps_pkg::PARTICLE_W-1:0]       rd_particle,
   input  wire abps_pkg::tag_type                     s1_tag,
   input  wire logic signed [abps_pkg::HPROD_W-1:0]   s1_hprod,
   output logic [abps_pkg::HEADING_W-1:0]             heading_out,
   output logic                                       busy
);

   localparam int DEPTH = abps_pkg::mem_depth(NUM_PARTICLES);
   localparam int AW    = abps_pkg::addr_width(DEPTH);
   localparam int HW    = abps_pkg::HEADING_W;
   localparam int FRAC  = 12;

   logic [HW-1:0]      mem [DEPTH];
   logic [HW-1:0]      rdata_ff;
   logic               clearing_ff;
   logic [AW-1:0]      clr_cnt_ff;
   abps_pkg::tag_type  s2_tag_ff;
   logic [HW-1:0]      heading_ff;
   logic [HW-1:0]      heading_in;
   logic [HW-1:0]      old_heading;
   logic [HW-1:0]      heading_add;
   logic signed [abps_pkg::HPROD_W-1:0] hsum;
   logic               forward;
   logic               write_en;

   assign hsum        = s1_hprod + abps_pkg::HPROD_W'(1 << (FRAC - 1));
   assign heading_add = hsum[HW+FRAC-1:FRAC];
   assign forward     = s2_tag_ff.valid && s2_tag_ff.live
                        && (s2_tag_ff.particle == s1_tag.particle);
   assign old_heading = forward ? heading_ff : rdata_ff;
   assign write_en    = s1_tag.valid && s1_tag.live;

   always_comb begin
      if (s1_tag.live && (s1_tag.op == abps_pkg::OP_STEP)) begin
         heading_in = old_heading + heading_add;
      end else begin
         heading_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_particle[AW-1:0]];
      if (clearing_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (write_en) begin
         mem[s1_tag.particle[AW-1:0]] <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff     <= 1'b1;
         clr_cnt_ff      <= '0;
         s2_tag_ff.valid <= 1'b0;
      end else begin
         if (clearing_ff) begin
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end else begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
            end
         end
         s2_tag_ff <= s1_tag;
      end
      heading_ff <= heading_in;
   end

   assign heading_out = heading_ff;
   assign busy        = clearing_ff;

endmodule

`default_nettype wire

// ===== design/abps_sine.sv =====
// ----------------------------------------------------------------------------
// Pipelined table-free sine
// Quarter-wave folding and an odd seventh-order polynomial, one multiply per
// stage, giving a registered Q1.15 value.
// ----------------------------------------------------------------------------
`default_nettype none

module abps_sine (
   input  wire logic                                clock,
   input  wire logic [abps_pkg::HEADING_W-1:0]      phase,
   output logic signed [abps_pkg::TRIG_W-1:0]       trig
);

   localparam int HW    = abps_pkg::HEADING_W;
   localparam int TW    = HW - 1;
   localparam int T_W   = HW + 1;
   localparam int ACC_W = 20;
   localparam int P_W   = ACC_W + T_W;
   localparam int S_W   = P_W - 15;

   localparam logic signed [ACC_W-1:0] K1 = ACC_W'(-307);
   localparam logic signed [ACC_W-1:0] K3 = ACC_W'(5223);
   localparam logic signed [ACC_W-1:0] K5 = ACC_W'(-42334);
   localparam logic signed [ACC_W-1:0] K7 = ACC_W'(102944);
   localparam logic signed [S_W-1:0]   S_MAX = S_W'((1 << (abps_pkg::TRIG_W - 1)) - 1);

   logic [1:0]              quad_a_ff, quad_b_ff, quad_c_ff, quad_d_ff, quad_e_ff;
   logic [TW-1:0]           t_in, t_a_ff;
   logic [2*TW-1:0]         tt_a_ff;
   logic signed [T_W-1:0]   t_b_ff, t_c_ff, t_d_ff;
   logic signed [T_W-1:0]   t2_in, t2_b_ff, t2_c_ff;
   logic signed [P_W-1:0]   m1_in, m1_b_ff;
   logic signed [ACC_W-1:0] acc1, acc2, acc3;
   logic signed [P_W-1:0]   m2_in, m2_c_ff;
   logic signed [P_W-1:0]   m3_in, m3_d_ff;
   logic signed [P_W-1:0]   m4_in, m4_e_ff;
   logic signed [S_W-1:0]   s_raw;
   logic signed [abps_pkg::TRIG_W-1:0] s_clamp, trig_in, trig_ff;

   always_comb begin
      if (phase[HW-2]) begin
         t_in = TW'(1 << (HW - 2)) - {1'b0, phase[HW-3:0]};
      end else begin
         t_in = {1'b0, phase[HW-3:0]};
      end
   end

   assign t2_in = T_W'(tt_a_ff[2*TW-1:HW-2]);
   assign m1_in = K1 * t2_in;
   assign acc1  = K3 + m1_b_ff[ACC_W+13:14];
   assign m2_in = acc1 * t2_b_ff;
   assign acc2  = K5 + m2_c_ff[ACC_W+13:14];
   assign m3_in = acc2 * t2_c_ff;
   assign acc3  = K7 + m3_d_ff[ACC_W+13:14];
   assign m4_in = acc3 * t_d_ff;
   assign s_raw = m4_e_ff[P_W-1:15];

   always_comb begin
      if (s_raw < 0) begin
         s_clamp = '0;
      end else if (s_raw > S_MAX) begin
         s_clamp = S_MAX[abps_pkg::TRIG_W-1:0];
      end else begin
         s_clamp = s_raw[abps_pkg::TRIG_W-1:0];
      end
      trig_in = quad_e_ff[1] ? -s_clamp : s_clamp;
   end

   always_ff @(posedge clock) begin
      quad_a_ff <= phase[HW-1:HW-2];
      t_a_ff    <= t_in;
      tt_a_ff   <= t_in * t_in;

      quad_b_ff <= quad_a_ff;
      t_b_ff    <= T_W'(t_a_ff);
      t2_b_ff   <= t2_in;
      m1_b_ff   <= m1_in;

      quad_c_ff <= quad_b_ff;
      t_c_ff    <= t_b_ff;
      t2_c_ff   <= t2_b_ff;
      m2_c_ff   <= m2_in;

      quad_d_ff <= quad_c_ff;
      t_d_ff    <= t_c_ff;
      m3_d_ff   <= m3_in;

      quad_e_ff <= quad_d_ff;
      m4_e_ff   <= m4_in;

      trig_ff   <= trig_in;
   end

   assign trig = trig_ff;

endmodule

`default_nettype wire

// ===== design/abps_position.sv =====
// ----------------------------------------------------------------------------
// Position update stage
// Scales the heading trig values by the step length, adds positional noise,
// reads and writes back the position memory with forwarding, and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module abps_position #(
   parameter int NUM_PARTICLES = abps_pkg::NUM_PARTICLES_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire abps_pkg::tag_type                     in_tag,
   input  wire logic [abps_pkg::HEADING_W-1:0]        in_heading,
   input  wire logic signed [abps_pkg::TRIG_W-1:0]    cos_trig,
   input  wire logic signed [abps_pkg::TRIG_W-1:0]    sin_trig,
   input  wire logic signed [abps_pkg::POS_W-1:0]     load_x,
   input  wire logic signed [abps_pkg::POS_W-1:0]     load_y,
   input  wire logic signed [abps_pkg::NPROD_W-1:0]   x_nprod,
   input  wire logic signed [abps_pkg::NPROD_W-1:0]   y_nprod,
   input  wire logic [abps_pkg::STEP_W-1:0]           speed_step,
   output logic                                       out_valid,
   output logic [abps_pkg::PARTICLE_W-1:0]            out_particle,
   output logic signed [abps_pkg::POS_W-1:0]          new_x,
   output logic signed [abps_pkg::POS_W-1:0]          new_y,
   output logic [abps_pkg::HEADING_W-1:0]             new_heading,
   output logic                                       saturated
);

   localparam int DEPTH = abps_pkg::mem_depth(NUM_PARTICLES);
   localparam int AW    = abps_pkg::addr_width(DEPTH);
   localparam int PW    = abps_pkg::POS_W;
   localparam int NW    = abps_pkg::NPROD_W;
   localparam int SUM_W = NW + 4;
   localparam int SHIFT = 15;
   localparam int D_W   = SUM_W - SHIFT;

   localparam logic signed [PW:0] POS_MAX = {2'b00, {(PW - 1){1'b1}}};
   localparam logic signed [PW:0] POS_MIN = {2'b11, {(PW - 1){1'b0}}};

   logic [2*PW-1:0]          mem [DEPTH];
   logic [2*PW-1:0]          rdata_ff;

   logic signed [abps_pkg::TRIG_W-1:0] trig [2];
   logic signed [PW-1:0]     load_lane [2];
   logic signed [NW-1:0]     nprod_lane [2];

   abps_pkg::tag_type        tag9_ff, tag10_ff, out_tag_ff;
   logic [abps_pkg::HEADING_W-1:0] hd9_ff, hd10_ff, out_hd_ff;
   logic signed [NW-1:0]     prod9_ff [2];
   logic signed [NW-1:0]     nprod9_ff [2];
   logic signed [PW-1:0]     load9_ff [2];
   logic signed [PW-1:0]     load10_ff [2];
   logic signed [D_W-1:0]    d10_ff [2];
   logic signed [D_W-1:0]    d_in [2];
   logic signed [PW-1:0]     pos_old [2];
   logic signed [PW-1:0]     pos_in [2];
   logic signed [PW-1:0]     pos_ff [2];
   logic [1:0]               clip;
   logic                     sat_in, sat_ff;
   logic                     forward;
   logic signed [SUM_W-1:0]  sum [2];
   logic signed [PW:0]       v [2];

   assign trig[0]       = cos_trig;
   assign trig[1]       = sin_trig;
   assign load_lane[0]  = load_x;
   assign load_lane[1]  = load_y;
   assign nprod_lane[0] = x_nprod;
   assign nprod_lane[1] = y_nprod;

   assign forward = out_tag_ff.valid && out_tag_ff.live
                    && (out_tag_ff.particle == tag10_ff.particle);
   assign pos_old[0] = forward ? pos_ff[0] : $signed(rdata_ff[PW-1:0]);
   assign pos_old[1] = forward ? pos_ff[1] : $signed(rdata_ff[2*PW-1:PW]);

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         sum[k]  = SUM_W'(prod9_ff[k]) + (SUM_W'(nprod9_ff[k]) <<< 3)
                   + SUM_W'(1 << (SHIFT - 1));
         d_in[k] = sum[k][SUM_W-1:SHIFT];
         v[k]    = (PW + 1)'(pos_old[k]) + (PW + 1)'(d10_ff[k]);
         clip[k] = 1'b0;
         if (!tag10_ff.live) begin
            pos_in[k] = '0;
         end else if (tag10_ff.op == abps_pkg::OP_LOAD) begin
            pos_in[k] = load10_ff[k];
         end else if (v[k] > POS_MAX) begin
            pos_in[k] = POS_MAX[PW-1:0];
            clip[k]   = 1'b1;
         end else if (v[k] < POS_MIN) begin
            pos_in[k] = POS_MIN[PW-1:0];
            clip[k]   = 1'b1;
         end else begin
            pos_in[k] = v[k][PW-1:0];
         end
      end
      sat_in = |clip;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[tag9_ff.particle[AW-1:0]];
      if (tag10_ff.valid && tag10_ff.live) begin
         mem[tag10_ff.particle[AW-1:0]] <= {pos_in[1], pos_in[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag9_ff.valid    <= 1'b0;
         tag10_ff.valid   <= 1'b0;
         out_tag_ff.valid <= 1'b0;
      end else begin
         tag9_ff    <= in_tag;
         tag10_ff   <= tag9_ff;
         out_tag_ff <= tag10_ff;
      end
      hd9_ff    <= in_heading;
      hd10_ff   <= hd9_ff;
      out_hd_ff <= hd10_ff;
      sat_ff    <= sat_in;
      for (int k = 0; k < 2; k++) begin
         prod9_ff[k]  <= $signed({1'b0, speed_step}) * trig[k];
         nprod9_ff[k] <= nprod_lane[k];
         load9_ff[k]  <= load_lane[k];
         load10_ff[k] <= load9_ff[k];
         d10_ff[k]    <= d_in[k];
         pos_ff[k]    <= pos_in[k];
      end
   end

   assign out_valid    = out_tag_ff.valid;
   assign out_particle = out_tag_ff.particle;
   assign new_x        = pos_ff[0];
   assign new_y        = pos_ff[1];
   assign new_heading  = out_hd_ff;
   assign saturated    = sat_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_active_brownian_particle_step_unit.sv =====
// ----------------------------------------------------------------------------
// Active Brownian particle step unit testbench
// Drives load and step requests through the start/busy port, and writes the
// gain registers between phases once all results are in. A scoreboard keeps
// its own copy of every particle's position and heading and of the registers.
// It predicts each result in fixed point and checks every rsp_valid cycle
// against the oldest prediction, field by field. A short directed part covers
// heading quadrants, wrap, saturation and back-to-back updates. Random phases
// follow under varied register settings.
// ----------------------------------------------------------------------------
module tb_active_brownian_particle_step_unit;
   import abps_pkg::*;

   localparam int     NUM_PARTS = NUM_PARTICLES_DEFAULT;
   localparam longint POS_MAX   = 64'sd2147483647;
   localparam longint POS_MIN   = -64'sd2147483648;

   typedef struct {
      logic                        op;
      logic [PARTICLE_W-1:0]       particle;
      logic signed [POS_W-1:0]     load_x;
      logic signed [POS_W-1:0]     load_y;
      logic signed [NOISE_W-1:0]   angle_noise;
      logic signed [NOISE_W-1:0]   x_noise;
      logic signed [NOISE_W-1:0]   y_noise;
   } particle_request_t;

   typedef struct {
      logic [PARTICLE_W-1:0]       particle;
      logic signed [POS_W-1:0]     x;
      logic signed [POS_W-1:0]     y;
      logic [HEADING_W-1:0]        heading;
      logic                        saturated;
   } particle_state_t;

   class particle_scoreboard;
      logic [HGAIN_W-1:0]      heading_gain;
      logic [STEP_W-1:0]       speed_step;
      logic [STEP_W-1:0]       position_gain;
      logic signed [POS_W-1:0] x_pos [NUM_PARTS];
      logic signed [POS_W-1:0] y_pos [NUM_PARTS];
      logic [HEADING_W-1:0]    heading [NUM_PARTS];
      particle_state_t         expected_states [$];
      int                      mismatches;
      int                      loads;
      int                      steps;
      int                      clamped;

      function new();
         heading_gain = '0;
         speed_step = '0;
         position_gain = '0;
         mismatches = 0;
         loads = 0;
         steps = 0;
         clamped = 0;
         foreach (heading[i]) begin
            x_pos[i] = '0;
            y_pos[i] = '0;
            heading[i] = '0;
         end
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_HEADING_GAIN:  heading_gain = data[HGAIN_W-1:0];
            CSR_SPEED_STEP:    speed_step = data[STEP_W-1:0];
            CSR_POSITION_GAIN: position_gain = data[STEP_W-1:0];
            default: ;
         endcase
      endfunction

      // Quarter-wave sine in Q1.15 from an odd polynomial; every shift floors.
      function longint sine_q15(logic [HEADING_W-1:0] phase);
         longint t, t2, acc, s;
         t = phase[13:0];
         if (phase[14]) t = 16384 - t;
         t2 = (t * t) >>> 14;
         acc = -307;
         acc = 5223 + ((acc * t2) >>> 14);
         acc = -42334 + ((acc * t2) >>> 14);
         acc = 102944 + ((acc * t2) >>> 14);
         s = (acc * t) >>> 15;
         if (s < 0) s = 0;
         if (s > 32767) s = 32767;
         return phase[15] ? -s : s;
      endfunction

      function longint move_coord(longint pos, longint trig, longint noise, inout bit sat);
         longint spd, gain, v;
         spd = speed_step;
         gain = position_gain;
         v = pos + ((spd * trig + gain * noise * 8 + 16384) >>> 15);
         if (v > POS_MAX) begin
            sat = 1'b1;
            v = POS_MAX;
         end
         if (v < POS_MIN) begin
            sat = 1'b1;
            v = POS_MIN;
         end
         return v;
      endfunction

      function particle_state_t advance_particle(particle_request_t r);
         particle_state_t res;
         longint prod, nx, ny;
         logic [HEADING_W-1:0] nh, cos_phase;
         bit sat;
         res = '{r.particle, '0, '0, '0, 1'b0};
         sat = 1'b0;
         if (r.particle >= NUM_PARTS) return res;
         if (r.op == OP_LOAD) begin
            loads++;
            nx = r.load_x;
            ny = r.load_y;
            nh = '0;
         end else begin
            steps++;
            prod = longint'(heading_gain) * longint'(r.angle_noise) + 2048;
            nh = heading[r.particle] + HEADING_W'(prod >>> 12);
            cos_phase = nh + QUARTER_TURN;
            nx = move_coord(x_pos[r.particle], sine_q15(cos_phase), r.x_noise, sat);
            ny = move_coord(y_pos[r.particle], sine_q15(nh), r.y_noise, sat);
         end
         x_pos[r.particle] = POS_W'(nx);
         y_pos[r.particle] = POS_W'(ny);
         heading[r.particle] = nh;
         res.x = POS_W'(nx);
         res.y = POS_W'(ny);
         res.heading = nh;
         res.saturated = sat;
         return res;
      endfunction

      function void note_request(particle_request_t r);
         expected_states.push_back(advance_particle(r));
      endfunction

      function void compare_field(string field, logic [PARTICLE_W-1:0] p,
                                  logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: particle %0d %s expected %h actual %h", $time, p, field, want, got);
         end
      endfunction

      function void check_result(particle_state_t got);
         particle_state_t want;
         if (expected_states.size() == 0) begin
            mismatches++;
            $display("%0t: result for particle %0d with no request outstanding",
                     $time, got.particle);
            return;
         end
         want = expected_states.pop_front();
         if (got.saturated) clamped++;
         compare_field("out_particle", want.particle, 32'(want.particle), 32'(got.particle));
         compare_field("new_x", want.particle, want.x, got.x);
         compare_field("new_y", want.particle, want.y, got.y);
         compare_field("new_heading", want.particle, 32'(want.heading), 32'(got.heading));
         compare_field("saturated", want.particle, 32'(want.saturated), 32'(got.saturated));
      endfunction

      function int pending();
         return expected_states.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_op = OP_LOAD;
   logic [PARTICLE_W-1:0]       req_particle = '0;
   logic signed [POS_W-1:0]     req_load_x = '0;
   logic signed [POS_W-1:0]     req_load_y = '0;
   logic signed [NOISE_W-1:0]   req_angle_noise = '0;
   logic signed [NOISE_W-1:0]   req_x_noise = '0;
   logic signed [NOISE_W-1:0]   req_y_noise = '0;
   logic                        rsp_valid;
   logic [PARTICLE_W-1:0]       rsp_out_particle;
   logic signed [POS_W-1:0]     rsp_new_x;
   logic signed [POS_W-1:0]     rsp_new_y;
   logic [HEADING_W-1:0]        rsp_new_heading;
   logic                        rsp_saturated;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index = CSR_HEADING_GAIN;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   particle_scoreboard sb = new();

   int                    idle_pct = 27;
   int                    settings_used = 0;
   bit                    loaded [NUM_PARTS];
   logic [PARTICLE_W-1:0] hot_particles [8];
   logic [PARTICLE_W-1:0] last_particle = '0;

   active_brownian_particle_step_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_particle(req_particle),
      .req_load_x(req_load_x),
      .req_load_y(req_load_y),
      .req_angle_noise(req_angle_noise),
      .req_x_noise(req_x_noise),
      .req_y_noise(req_y_noise),
      .rsp_valid(rsp_valid),
      .rsp_out_particle(rsp_out_particle),
      .rsp_new_x(rsp_new_x),
      .rsp_new_y(rsp_new_y),
      .rsp_new_heading(rsp_new_heading),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("active_brownian_particle_step_unit regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result(particle_state_t'{rsp_out_particle, rsp_new_x, rsp_new_y,
                                              rsp_new_heading, rsp_saturated});
         if (start && !busy)
            sb.note_request(particle_request_t'{req_op, req_particle, req_load_x,
                                                req_load_y, req_angle_noise,
                                                req_x_noise, req_y_noise});
         if (csr_valid && csr_ready)
            sb.set_register(csr_index, csr_wdata);
      end
   end

   task automatic send_request(particle_request_t r);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_op <= r.op;
      req_particle <= r.particle;
      req_load_x <= r.load_x;
      req_load_y <= r.load_y;
      req_angle_noise <= r.angle_noise;
      req_x_noise <= r.x_noise;
      req_y_noise <= r.y_noise;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic apply_settings(logic [CSR_DATA_W-1:0] h_gain, logic [CSR_DATA_W-1:0] spd,
                                 logic [CSR_DATA_W-1:0] p_gain);
      logic [CSR_INDEX_W-1:0] codes [3];
      logic [CSR_DATA_W-1:0]  vals [3];
      codes = '{CSR_HEADING_GAIN, CSR_SPEED_STEP, CSR_POSITION_GAIN};
      vals = '{h_gain, spd, p_gain};
      wait_drained();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= codes[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic load_particle(logic [PARTICLE_W-1:0] p, logic [POS_W-1:0] x,
                                logic [POS_W-1:0] y);
      loaded[p] = 1'b1;
      send_request('{OP_LOAD, p, x, y, '0, '0, '0});
   endtask

   task automatic step_particle(logic [PARTICLE_W-1:0] p, logic signed [NOISE_W-1:0] an,
                                logic signed [NOISE_W-1:0] xn,
                                logic signed [NOISE_W-1:0] yn);
      send_request('{OP_STEP, p, '0, '0, an, xn, yn});
   endtask

   function automatic logic [POS_W-1:0] random_position();
      logic [21:0] near;
      near = 22'($urandom);
      case ($urandom_range(0, 3))
         0, 1: return $urandom;
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF - 32'(near[15:0])
                                        : 32'h80000000 + 32'(near[15:0]);
         default: return {{10{near[21]}}, near};
      endcase
   endfunction

   function automatic logic [NOISE_W-1:0] random_noise();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      return 16'($urandom);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_setting(logic [CSR_DATA_W-1:0] limit);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return limit;
         2: return CSR_DATA_W'($urandom) & limit;
         default: return CSR_DATA_W'($urandom_range(0, 'h3FFFF)) & limit;
      endcase
   endfunction

   // Most requests go to a few particles, often the same one twice in a row,
   // so that headings and positions evolve over many steps.
   function automatic particle_request_t random_request();
      particle_request_t r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) r.particle = last_particle;
      else if (pick < 70) r.particle = hot_particles[$urandom_range(0, 7)];
      else r.particle = PARTICLE_W'($urandom);
      r.load_x = random_position();
      r.load_y = random_position();
      r.angle_noise = random_noise();
      r.x_noise = random_noise();
      r.y_noise = random_noise();
      if (!loaded[r.particle] || $urandom_range(0, 99) < 12) begin
         r.op = OP_LOAD;
         loaded[r.particle] = 1'b1;
      end else begin
         r.op = OP_STEP;
      end
      last_particle = r.particle;
      return r;
   endfunction

   initial begin
      foreach (hot_particles[i]) hot_particles[i] = PARTICLE_W'($urandom);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      apply_settings(24'd4096, 24'h010000, 24'h001000);
      load_particle(10'd0, 32'h00000000, 32'h00000000);
      load_particle(10'd1023, 32'h7FFFFFFF, 32'h80000000);
      load_particle(10'd512, 32'hFFFFFFFF, 32'h00000001);
      step_particle(10'd0, 16'sd16384, 16'sd0, 16'sd0);
      step_particle(10'd0, 16'sd16384, 16'sd0, 16'sd0);
      step_particle(10'd0, 16'sd16384, 16'sd0, 16'sd0);
      step_particle(10'd0, 16'sd16383, 16'sd0, 16'sd0);
      step_particle(10'd0, 16'sd1, 16'sd0, 16'sd0);
      step_particle(10'd0, -16'sd32768, 16'sd32767, -16'sd32768);
      step_particle(10'd0, 16'sd32767, -16'sd32768, 16'sd32767);
      step_particle(10'd1023, 16'sd0, 16'sd32767, -16'sd32768);
      step_particle(10'd512, 16'sd8192, 16'sd0, 16'sd0);
      load_particle(10'd5, 32'h12345678, 32'hEDCBA987);
      step_particle(10'd5, 16'sd100, 16'sd1, -16'sd1);

      apply_settings(24'h00FFFF, 24'hFFFFFF, 24'hFFFFFF);
      step_particle(10'd1023, -16'sd32768, -16'sd32768, 16'sd32767);
      step_particle(10'd512, 16'sd32767, 16'sd32767, 16'sd32767);
      step_particle(10'd512, -16'sd1, -16'sd1, -16'sd1);
      load_particle(10'd1023, 32'h80000000, 32'h7FFFFFFF);
      step_particle(10'd1023, 16'sd0, -16'sd32768, 16'sd32767);
      step_particle(10'd5, 16'sd1, 16'sd0, 16'sd0);

      apply_settings(24'h0, 24'h0, 24'h0);
      step_particle(10'd0, 16'sd32767, 16'sd32767, 16'sd32767);
      step_particle(10'd1023, -16'sd32768, -16'sd32768, -16'sd32768);

      for (int phase = 0; phase < 7; phase++) begin
         idle_pct = (phase == 2) ? 0 : 27;
         apply_settings(random_setting(24'h00FFFF), random_setting(24'hFFFFFF),
                        random_setting(24'hFFFFFF));
         repeat (150) send_request(random_request());
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) sb.mismatches++;
      $display("Covered %0d loads and %0d steps under %0d register settings.",
               sb.loads, sb.steps, settings_used);
      $display("%0d results were clamped; %0d mismatches found.", sb.clamped, sb.mismatches);
      if (sb.mismatches == 0)
         $display("active_brownian_particle_step_unit regression: pass");
      else
         $display("active_brownian_particle_step_unit regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
design/abps_pkg.sv
design/abps_heading.sv
design/abps_sine.sv
design/abps_position.sv
design/active_brownian_particle_step_unit.sv
tb/sv/tb_active_brownian_particle_step_unit.sv
